// ===== sv/lzd_pkg.sv =====
// lzd_pkg: shared types, codes and defaults for the LZ78 dictionary table.
// No dependencies; the top level and the bench import it.
`default_nettype none
package lzd_pkg;
   localparam int TABLE_DEPTH_DEF = 8192;
   localparam int NODE_BITS = 16;
   localparam int SYM_SHIFT = 8;
   localparam int KEY_BITS = NODE_BITS + SYM_SHIFT;

   localparam logic [NODE_BITS-1:0] ROOT_CODE  = '1;
   localparam logic [NODE_BITS-1:0] EMPTY_CODE = ROOT_CODE - 1'b1;
   localparam logic [8:0] EOF_SYM = 9'd256;

   localparam logic [2:0] MODE_INIT   = 3'd0;
   localparam logic [2:0] MODE_REINIT = 3'd1;
   localparam logic [2:0] MODE_LOOKUP = 3'd2;
   localparam logic [2:0] MODE_FILL   = 3'd3;
   localparam logic [2:0] MODE_FIRST  = 3'd4;

   localparam logic [1:0] ST_MISS    = 2'd0;
   localparam logic [1:0] ST_HIT     = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_DONE    = 2'd3;

   localparam logic [1:0] CSR_TABLE_SLOTS   = 2'd0;
   localparam logic [1:0] CSR_ALPHABET_SIZE = 2'd1;
   localparam logic [1:0] CSR_MAX_NODES     = 2'd2;
   localparam logic [1:0] CSR_COMPRESS_MODE = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] node;
      logic [8:0]  symbol;
      logic [12:0] slot;
      logic [15:0] child_code;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [12:0] found_slot;
      logic [15:0] found_code;
      logic [8:0]  first_symbol;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SWEEP, S_DIV, S_PROBE_RD, S_PROBE_CHK, S_WALK_RD, S_WALK_CHK, S_RESP
   } state_type;
endpackage
`default_nettype wire

// ===== sv/lzd_ram.sv =====
// lzd_ram: generic single-port RAM, one access a cycle (a read, plus a write when we is high), registered read.
// No dependencies.
`default_nettype none
module lzd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== sv/lzd_divider.sv =====
// lzd_divider: restoring remainder unit, one quotient bit a cycle.
// Depends on nothing but its parameters.
`default_nettype none
module lzd_divider #(
   parameter int KW = 24,
   parameter int DW = 14
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [KW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic      [DW-1:0] remainder
);
   localparam int CNW = $clog2(KW + 1);

   logic [KW-1:0]  q_ff, q_in;
   logic [DW-1:0]  d_ff, d_in;
   logic [DW-1:0]  r_ff, r_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           run_ff, run_in;
   logic           done_ff, done_in;
   logic [DW:0]    sh;

   always_comb begin
      q_in    = q_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      sh      = {r_ff, q_ff[KW-1]};
      if (start) begin
         q_in   = dividend;
         d_in   = divisor;
         r_in   = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            sh = sh - {1'b0, d_ff};
         end
         r_in   = sh[DW-1:0];
         q_in   = {q_ff[KW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNW'(KW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = r_ff;
endmodule
`default_nettype wire

// ===== sv/lz78_dictionary_table_top.sv =====
// LZ78 dictionary hash table. One beat at a time; req_stall is high while busy.
// Fill writes on acceptance; a root lookup reads its slot directly; a hashed lookup
// runs the divider, then probes slot by slot; first_symbol walks parent links to a
// root; init/reinit sweep one slot a cycle. The three stores share one address.
// Reset (synchronous, active high) restores the state and configuration registers;
// table contents are undefined until an init beat.
`default_nettype none
module lz78_dictionary_table_top #(
   parameter int TABLE_DEPTH = lzd_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lzd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lzd_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [13:0]      csr_wdata
);
   import lzd_pkg::*;

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int TSW = $clog2(TABLE_DEPTH + 1);
   localparam int CW  = (TSW > 14) ? TSW : 14;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   // configuration
   logic [13:0] slots_ff;
   logic [8:0]  alpha_ff;
   logic [12:0] maxn_ff;
   logic        comp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= 14'd8192;
         alpha_ff <= 9'd256;
         maxn_ff  <= 13'd4096;
         comp_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TABLE_SLOTS:   slots_ff <= csr_wdata;
            CSR_ALPHABET_SIZE: alpha_ff <= csr_wdata[8:0];
            CSR_MAX_NODES:     maxn_ff  <= csr_wdata[12:0];
            CSR_COMPRESS_MODE: comp_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective slots, first non-root slot, hashed span
   logic [CW-1:0] ts, lo, span;
   assign ts   = (CW'(slots_ff) < DEPTH_C) ? CW'(slots_ff) : DEPTH_C;
   assign lo   = CW'(alpha_ff) + 1'b1;
   assign span = ts - lo;

   state_type     state_ff, state_in;
   req_type       op_ff, op_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          root_ff, root_in;
   rsp_type       rsp_ff, rsp_in;

   logic accept;
   assign accept = req_valid && !req_stall;

   // request checks, taken straight off the input beat
   logic node_bad, lk_bad, fill_bad, first_bad;
   assign node_bad  = (req_data.node >= 16'(maxn_ff)) && (req_data.node != ROOT_CODE);
   assign lk_bad    = ((req_data.symbol >= alpha_ff) && (req_data.symbol != EOF_SYM))
                      || node_bad;
   assign fill_bad  = (CW'(req_data.slot) >= ts) || (req_data.symbol > alpha_ff) || node_bad;
   assign first_bad = (req_data.node >= 16'(maxn_ff))
                      || (32'(req_data.node) >= TABLE_DEPTH);

   // remainder unit for the hash
   logic              div_start, div_done;
   logic [CW-1:0]     div_rem;
   logic [KEY_BITS-1:0] key;
   assign key = {req_data.node, {SYM_SHIFT{1'b0}}} | KEY_BITS'(req_data.symbol);

   lzd_divider #(.KW(KEY_BITS), .DW(CW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(key),
      .divisor(span), .done(div_done), .remainder(div_rem)
   );

   // table stores
   logic                 p_we, s_we, c_we;
   logic [AW-1:0]        ram_addr;
   logic [NODE_BITS-1:0] p_wd, p_q;
   logic [7:0]           s_wd, s_q;
   logic [15:0]          c_wd, c_q;

   lzd_ram #(.WIDTH(NODE_BITS), .DEPTH(TABLE_DEPTH)) u_parent (
      .clock(clock), .we(p_we), .addr(ram_addr), .wdata(p_wd), .rdata(p_q));
   lzd_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_symbol (
      .clock(clock), .we(s_we), .addr(ram_addr), .wdata(s_wd), .rdata(s_q));
   lzd_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_child (
      .clock(clock), .we(c_we), .addr(ram_addr), .wdata(c_wd), .rdata(c_q));

   logic [CW-1:0] idx_inc, cnt_inc;
   logic          sweep_last, probe_match;
   assign idx_inc     = idx_ff + 1'b1;
   assign cnt_inc     = cnt_ff + 1'b1;
   assign sweep_last  = idx_inc >= ts;
   assign probe_match = (p_q == op_ff.node) && (s_q == op_ff.symbol[7:0])
                        && !op_ff.symbol[8];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  MODE_INIT:   state_in = (ts == '0) ? S_RESP : S_SWEEP;
                  MODE_REINIT: state_in = (lo >= ts) ? S_RESP : S_SWEEP;
                  MODE_LOOKUP: begin
                     priority if (lk_bad)                     state_in = S_RESP;
                     else if (req_data.node == ROOT_CODE)     state_in = S_PROBE_RD;
                     else if (ts <= lo)                       state_in = S_RESP;
                     else                                     state_in = S_DIV;
                  end
                  MODE_FIRST:  state_in = first_bad ? S_RESP : S_WALK_RD;
                  default:     state_in = S_RESP;
               endcase
            end
         end
         S_SWEEP:     if (sweep_last) state_in = S_RESP;
         S_DIV:       if (div_done) state_in = S_PROBE_RD;
         S_PROBE_RD:  state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            if (root_ff || probe_match || (p_q == EMPTY_CODE) || (cnt_inc >= span)) begin
               state_in = S_RESP;
            end else begin
               state_in = S_PROBE_RD;
            end
         end
         S_WALK_RD:   state_in = S_WALK_CHK;
         S_WALK_CHK: begin
            if ((p_q == ROOT_CODE) || (32'(p_q) >= TABLE_DEPTH)
                || (cnt_inc >= DEPTH_C)) begin
               state_in = S_RESP;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_RESP:      if (!rsp_stall) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and store controls
   always_comb begin
      op_in     = op_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      root_in   = root_ff;
      rsp_in    = rsp_ff;
      div_start = 1'b0;
      p_we      = 1'b0;
      s_we      = 1'b0;
      c_we      = 1'b0;
      p_wd      = EMPTY_CODE;
      s_wd      = idx_ff[7:0];
      c_wd      = 16'(idx_ff);
      ram_addr  = AW'(idx_ff);
      unique case (state_ff)
         S_IDLE: begin
            ram_addr = AW'(req_data.slot);
            if (accept) begin
               op_in   = req_data;
               cnt_in  = '0;
               root_in = 1'b0;
               rsp_in  = '{status: ST_INVALID, found_slot: '0, found_code: '0,
                           first_symbol: EOF_SYM};
               unique case (req_data.mode)
                  MODE_INIT: begin
                     idx_in = '0;
                     rsp_in.status = ST_DONE;
                  end
                  MODE_REINIT: begin
                     idx_in = lo;
                     rsp_in.status = ST_DONE;
                  end
                  MODE_LOOKUP: begin
                     idx_in    = CW'(req_data.symbol);
                     root_in   = (req_data.node == ROOT_CODE);
                     div_start = !lk_bad && (req_data.node != ROOT_CODE) && (ts > lo);
                  end
                  MODE_FILL: begin
                     if (!fill_bad) begin
                        p_we = (req_data.node != ROOT_CODE);
                        p_wd = req_data.node;
                        s_we = 1'b1;
                        s_wd = req_data.symbol[7:0];
                        c_we = comp_ff;
                        c_wd = req_data.child_code;
                        rsp_in.status = ST_DONE;
                     end
                  end
                  MODE_FIRST:  idx_in = CW'(req_data.node);
                  default: ;
               endcase
            end
         end
         S_SWEEP: begin
            // init seeds roots then, when compressing, clears the rest;
            // reinit starts past the roots and only clears
            if ((op_ff.mode == MODE_INIT) && (idx_ff <= CW'(alpha_ff))) begin
               p_we = 1'b1;
               p_wd = ROOT_CODE;
               s_we = 1'b1;
               c_we = comp_ff;
            end else begin
               p_we = comp_ff || (op_ff.mode == MODE_REINIT);
            end
            idx_in = idx_inc;
         end
         S_DIV: begin
            if (div_done) begin
               idx_in = lo + div_rem;
            end
         end
         S_PROBE_RD: ;
         S_PROBE_CHK: begin
            priority if (root_ff || probe_match) begin
               rsp_in.status     = ST_HIT;
               rsp_in.found_slot = 13'(idx_ff);
               rsp_in.found_code = comp_ff ? c_q : '0;
            end else if (p_q == EMPTY_CODE) begin
               rsp_in.status     = ST_MISS;
               rsp_in.found_slot = 13'(idx_ff);
               rsp_in.found_code = comp_ff ? c_q : '0;
            end else begin
               cnt_in = cnt_inc;
               idx_in = (idx_inc >= ts) ? lo : idx_inc;
            end
         end
         S_WALK_RD: ;
         S_WALK_CHK: begin
            if (p_q == ROOT_CODE) begin
               rsp_in.status       = ST_DONE;
               rsp_in.first_symbol = {1'b0, s_q};
            end else begin
               cnt_in = cnt_inc;
               idx_in = CW'(p_q);
            end
         end
         S_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      root_ff <= root_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for the LZ78 dictionary table (lz78_dictionary_table_top).
// Depends on lzd_pkg and the top level; a behavioural table model predicts every response.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lzd_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam int STALL_LONG = 400;
   localparam int WDOG_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_TABLE_SLOTS;
   logic [13:0] csr_wdata = '0;

   lz78_dictionary_table_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow of the table and its registers
   logic [15:0] m_parent [DEPTH];
   logic [7:0]  m_sym    [DEPTH];
   logic [15:0] m_child  [DEPTH];
   int unsigned m_slots = 8192, m_alpha = 256, m_maxn = 4096, m_comp = 1;

   rsp_type     pending_rsp[$];
   int          mismatches = 0;
   int          wdog = 0;
   bit          hold_long = 0;
   bit          stim_done = 0;

   function automatic int unsigned slots_in_use();
      return (m_slots < DEPTH) ? m_slots : DEPTH;
   endfunction

   function automatic bit node_out_of_range(int unsigned n);
      return n >= m_maxn && n != ROOT_CODE;
   endfunction

   function automatic void mark_empty();
      for (int unsigned i = m_alpha + 1; i < slots_in_use(); i++) m_parent[i] = EMPTY_CODE;
   endfunction

   // walks the shadow table exactly as the block should
   function automatic rsp_type table_answer(req_type r);
      rsp_type     a;
      int unsigned ts, lo, span, idx, cur;
      longint unsigned key;
      a = '{status: ST_INVALID, found_slot: '0, found_code: '0, first_symbol: EOF_SYM};
      ts = slots_in_use();
      case (r.mode)
         MODE_INIT: begin
            for (int unsigned i = 0; i <= m_alpha && i < ts; i++) begin
               m_parent[i] = ROOT_CODE;
               m_sym[i] = i[7:0];
               if (m_comp) m_child[i] = i[15:0];
            end
            if (m_comp) mark_empty();
            a.status = ST_DONE;
         end
         MODE_REINIT: begin
            mark_empty();
            a.status = ST_DONE;
         end
         MODE_LOOKUP: begin
            if ((r.symbol >= m_alpha && r.symbol != EOF_SYM) || node_out_of_range(r.node))
               return a;
            if (r.node == ROOT_CODE) begin
               a.status = ST_HIT;
               idx = r.symbol;
            end else begin
               lo = m_alpha + 1;
               if (ts <= lo) return a;
               span = ts - lo;
               key = (longint'(r.node) << SYM_SHIFT) | r.symbol;
               idx = lo + int'(key % span);
               for (int unsigned n = 0; n < span; n++) begin
                  if (m_parent[idx] == r.node && {1'b0, m_sym[idx]} == r.symbol) begin
                     a.status = ST_HIT;
                     break;
                  end
                  if (m_parent[idx] == EMPTY_CODE) begin
                     a.status = ST_MISS;
                     break;
                  end
                  idx++;
                  if (idx >= ts) idx = lo;
               end
               if (a.status == ST_INVALID) return a;
            end
            a.found_slot = idx[12:0];
            if (m_comp && idx < DEPTH) a.found_code = m_child[idx];
         end
         MODE_FILL: begin
            if (r.slot >= ts || r.symbol > m_alpha || node_out_of_range(r.node)) return a;
            if (r.node != ROOT_CODE) m_parent[r.slot] = r.node;
            m_sym[r.slot] = r.symbol[7:0];
            if (m_comp) m_child[r.slot] = r.child_code;
            a.status = ST_DONE;
         end
         MODE_FIRST: begin
            if (r.node >= m_maxn || r.node >= DEPTH) return a;
            cur = r.node;
            for (int s = 0; s < DEPTH; s++) begin
               if (m_parent[cur] == ROOT_CODE) begin
                  a.status = ST_DONE;
                  a.first_symbol = {1'b0, m_sym[cur]};
                  break;
               end
               if (m_parent[cur] >= DEPTH) break;
               cur = m_parent[cur];
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus. Random beats must only touch slots the bench knows are
   // written, so the bench tracks which slots hold a defined entry.
   // ---------------------------------------------------------------
   bit written [DEPTH];
   bit fill_ok [DEPTH]; // slot holds a defined child code

   // fills the table's "known" flags after an init or reinit beat is predicted
   function automatic void note_written(req_type r);
      int unsigned ts;
      ts = slots_in_use();
      if (r.mode == MODE_INIT) begin
         for (int unsigned i = 0; i < ts; i++) begin
            if (i <= m_alpha || m_comp) written[i] = 1;
            if (i <= m_alpha && m_comp) fill_ok[i] = 1;
         end
      end else if (r.mode == MODE_REINIT) begin
         for (int unsigned i = m_alpha + 1; i < ts; i++) written[i] = 1;
      end
   endfunction

   // a read is safe if every slot the block may look at holds a defined entry
   function automatic bit read_is_safe(req_type r);
      int unsigned ts, cur;
      rsp_type     a;
      ts = slots_in_use();
      if (r.mode == MODE_LOOKUP) begin
         if ((r.symbol >= m_alpha && r.symbol != EOF_SYM) || node_out_of_range(r.node))
            return 1;
         if (r.node != ROOT_CODE) begin
            if (ts <= m_alpha + 1) return 1;
            for (int unsigned i = m_alpha + 1; i < ts; i++) if (!written[i]) return 0;
         end
         if (!m_comp) return 1;
         // compressing: the child code of the slot found is returned
         a = table_answer(r);
         if (a.status == ST_INVALID) return 1;
         return fill_ok[a.found_slot];
      end
      if (r.mode == MODE_FIRST) begin
         if (r.node >= m_maxn || r.node >= DEPTH) return 1;
         cur = r.node;
         for (int s = 0; s < DEPTH; s++) begin
            if (!written[cur]) return 0;
            if (m_parent[cur] == ROOT_CODE || m_parent[cur] >= DEPTH) return 1;
            cur = m_parent[cur];
         end
      end
      return 1;
   endfunction

   task automatic csr_write(input logic [1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[13:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TABLE_SLOTS:   m_slots = val & 14'h3FFF;
         CSR_ALPHABET_SIZE: m_alpha = val & 9'h1FF;
         CSR_MAX_NODES:     m_maxn = val & 13'h1FFF;
         default:           m_comp = val & 1;
      endcase
   endtask

   // one beat on the request side, predicted at acceptance; valid drops only
   // when an idle gap follows, so back-to-back beats keep it high
   task automatic send_beat(input req_type r, input bit has_fixed, input rsp_type fixed);
      rsp_type     a;
      int unsigned gap;
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      a = table_answer(r);
      note_written(r);
      if (r.mode == MODE_FILL && a.status == ST_DONE) begin
         written[r.slot] = 1;
         if (m_comp) fill_ok[r.slot] = 1;
      end
      if (has_fixed && a != fixed)
         $display("directed row expectation differs from table walk: %p vs %p", fixed, a);
      pending_rsp.push_back(has_fixed ? fixed : a);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // directed rows: request, and a typed expectation where obvious
   typedef struct {
      req_type r;
      bit      has_fixed;
      rsp_type fixed;
   } row_type;

   function automatic req_type mk(logic [2:0] m, logic [15:0] n, logic [8:0] s,
                                  logic [12:0] sl, logic [15:0] c);
      req_type r;
      r.mode = m; r.node = n; r.symbol = s; r.slot = sl; r.child_code = c;
      return r;
   endfunction

   function automatic rsp_type mr(logic [1:0] st, logic [12:0] fs, logic [15:0] fc,
                                  logic [8:0] sy);
      rsp_type a;
      a.status = st; a.found_slot = fs; a.found_code = fc; a.first_symbol = sy;
      return a;
   endfunction

   // random beat for the current settings, mostly well formed
   function automatic req_type rand_beat();
      req_type r;
      int unsigned ts, pick;
      ts = slots_in_use();
      r = mk(3'($urandom_range(2, 4)), 16'($urandom_range(0, m_maxn + 2)),
             9'($urandom_range(0, m_alpha)), 13'($urandom_range(0, ts)), 16'($urandom()));
      pick = $urandom_range(0, 99);
      if (pick < 8) r.node = ROOT_CODE;
      else if (pick < 10) r.node = 16'($urandom());
      if ($urandom_range(0, 19) == 0) r.symbol = 9'($urandom_range(0, 511));
      if ($urandom_range(0, 19) == 0) r.slot = 13'($urandom());
      if ($urandom_range(0, 29) == 0) r.mode = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 49) == 0) r.mode = MODE_REINIT;
      if (r.mode == MODE_FILL && r.slot <= m_alpha && $urandom_range(0, 3) != 0)
         r.slot = 13'(m_alpha + 1 +
                      $urandom_range(0, (ts > m_alpha + 1) ? ts - m_alpha - 2 : 0));
      return r;
   endfunction

   initial begin
      row_type rows[$];
      req_type r;
      int      sent;
      for (int i = 0; i < DEPTH; i++) begin
         m_parent[i] = '0; m_sym[i] = '0; m_child[i] = '0; written[i] = 0; fill_ok[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // small table first so init sweeps stay short
      csr_write(CSR_TABLE_SLOTS, 300);
      csr_write(CSR_ALPHABET_SIZE, 16);
      csr_write(CSR_MAX_NODES, 200);
      csr_write(CSR_COMPRESS_MODE, 1);
      rows.push_back('{mk(MODE_INIT, 0, 0, 0, 0), 1, mr(ST_DONE, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_LOOKUP, ROOT_CODE, 0, 0, 0), 1, mr(ST_HIT, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_LOOKUP, ROOT_CODE, 15, 0, 0), 1, mr(ST_HIT, 15, 15, EOF_SYM)});
      // give the EOF slot and the first probe slot of node 5 a child code
      rows.push_back('{mk(MODE_FILL, ROOT_CODE, 0, 256, 0), 1, mr(ST_DONE, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_FILL, ROOT_CODE, 0, 168, 16'h1234), 1,
                       mr(ST_DONE, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_LOOKUP, ROOT_CODE, EOF_SYM, 0, 0), 1,
                       mr(ST_HIT, 256, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_LOOKUP, ROOT_CODE, 16, 0, 0), 1, mr(ST_INVALID, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_LOOKUP, 200, 1, 0, 0), 1, mr(ST_INVALID, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_LOOKUP, 5, 3, 0, 0), 0, '0});
      rows.push_back('{mk(MODE_FILL, 5, 3, 100, 16'hFFFF), 1, mr(ST_DONE, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_FILL, ROOT_CODE, 16, 101, 17), 0, '0});
      rows.push_back('{mk(MODE_FILL, 100, 3, 300, 0), 1, mr(ST_INVALID, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_FILL, 100, 17, 120, 0), 1, mr(ST_INVALID, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_FILL, 3, 16, 299, 40), 0, '0});
      rows.push_back('{mk(MODE_LOOKUP, 5, 3, 0, 0), 0, '0});
      rows.push_back('{mk(MODE_FIRST, 3, 0, 0, 0), 1, mr(ST_DONE, 0, 0, 3)});
      rows.push_back('{mk(MODE_FIRST, 100, 0, 0, 0), 0, '0});
      rows.push_back('{mk(MODE_FIRST, 200, 0, 0, 0), 1, mr(ST_INVALID, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_FIRST, 16'hFFFF, 0, 0, 0), 1, mr(ST_INVALID, 0, 0, EOF_SYM)});
      rows.push_back('{mk(3'd5, 0, 0, 0, 0), 1, mr(ST_INVALID, 0, 0, EOF_SYM)});
      rows.push_back('{mk(3'd7, 16'hFFFF, 9'h1FF, 13'h1FFF, 16'hFFFF), 1,
                       mr(ST_INVALID, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_REINIT, 0, 0, 0, 0), 1, mr(ST_DONE, 0, 0, EOF_SYM)});
      rows.push_back('{mk(MODE_LOOKUP, 5, 3, 0, 0), 0, '0});
      foreach (rows[i]) send_beat(rows[i].r, rows[i].has_fixed, rows[i].fixed);
      wait_idle();

      // random phases across several settings: slots, alphabet, nodes, mode
      sent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin csr_write(CSR_TABLE_SLOTS, 40); csr_write(CSR_ALPHABET_SIZE, 1);
                      csr_write(CSR_MAX_NODES, 1); csr_write(CSR_COMPRESS_MODE, 1); end
            1: begin csr_write(CSR_TABLE_SLOTS, 60); csr_write(CSR_ALPHABET_SIZE, 8);
                      csr_write(CSR_MAX_NODES, 50); end
            2: begin csr_write(CSR_TABLE_SLOTS, 2); csr_write(CSR_ALPHABET_SIZE, 1);
                      csr_write(CSR_MAX_NODES, 1); end
            3: begin csr_write(CSR_TABLE_SLOTS, 16383); csr_write(CSR_ALPHABET_SIZE, 256);
                      csr_write(CSR_MAX_NODES, 8191); end
            4: begin csr_write(CSR_TABLE_SLOTS, 30); csr_write(CSR_ALPHABET_SIZE, 20);
                      csr_write(CSR_MAX_NODES, 29); csr_write(CSR_COMPRESS_MODE, 0); end
            default: begin csr_write(CSR_TABLE_SLOTS, 80); csr_write(CSR_ALPHABET_SIZE, 10);
                      csr_write(CSR_MAX_NODES, 60); csr_write(CSR_COMPRESS_MODE, 1); end
         endcase
         send_beat(mk(MODE_INIT, 0, 0, 0, 0), 0, '0);
         // decompress mode: fill every non-root slot before any probe reads it
         if (!m_comp)
            for (int unsigned i = m_alpha + 1; i < slots_in_use(); i++)
               send_beat(mk(MODE_FILL, 16'($urandom_range(0, m_maxn - 1)),
                             9'($urandom_range(0, m_alpha)), 13'(i), 16'($urandom())),
                         0, '0);
         if (ph == 1) hold_long = 1;
         for (int k = 0; k < (ph == 3 ? 25 : 100); k++) begin
            r = rand_beat();
            if (!read_is_safe(r)) r.mode = MODE_FILL;
            send_beat(r, 0, '0);
            sent++;
         end
         wait_idle();
      end
      stim_done = 1;
   end

   // receiver: random stalls plus one long hold-off while requests keep coming
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            hold_long = 0;
            rsp_stall <= 1'b1;
            repeat (STALL_LONG) @(posedge clock);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         rsp_stall <= (gap != 0);
         if (gap != 0) begin
            repeat (gap - 1) @(posedge clock);
            @(posedge clock);
            rsp_stall <= 1'b0;
         end
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with none expected: %p", rsp_data);
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status || rsp_data.found_slot !== e.found_slot ||
                rsp_data.found_code !== e.found_code ||
                rsp_data.first_symbol !== e.first_symbol) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, rsp_data);
            end
         end
      end
   end

   // watchdog on cycles without an accepted beat, a taken response or a CSR write, and end of run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/lzd_pkg.sv
sv/lzd_ram.sv
sv/lzd_divider.sv
sv/lz78_dictionary_table_top.sv
sim/tb.sv
